### sv/bed_pkg.sv
// Shared types and character constants for the backslash escape decoder.
package bed_pkg;

    // Character codes recognized by the decoder.
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_C         = 8'h63;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_X_LOWER   = 8'h78;
    localparam logic [7:0] CHAR_X_UPPER   = 8'h58;
    localparam logic [7:0] CHAR_0         = 8'h30;
    localparam logic [7:0] CHAR_7         = 8'h37;
    localparam logic [7:0] CHAR_9         = 8'h39;
    localparam logic [7:0] CHAR_A_LOWER   = 8'h61;
    localparam logic [7:0] CHAR_F_LOWER   = 8'h66;
    localparam logic [7:0] CHAR_A_UPPER   = 8'h41;
    localparam logic [7:0] CHAR_F_UPPER   = 8'h46;

    // Translated control characters.
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // Reset value of the color escape register.
    localparam logic [7:0] COLOR_RESET = 8'd28;

    // Depth of the result queue; one input item yields at most two results.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One decoded result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_end;
        logic       run_end;
    } result_t;

    // Results produced by decoding one input item.
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } dec_out_t;

endpackage

### sv/backslash_escape_decoder.sv
// Top level of the backslash escape decoder.
//
//   Channel   Signals                                        Direction
//   input     in_valid, in_stall, in_byte                    item in
//   output    out_valid, out_stall, out_byte, string_end,    item out
//             run_end
//   config    cfg_valid, cfg_ready, cfg_data                 color escape byte write
//
// An input item is registered, decoded by one level of logic and its zero to two
// results go into a two-entry result queue, so one item per cycle is accepted
// while in_stall is low. An item moves on once the queue has room for all its
// results, counting a result that leaves in the same cycle.
// Reset clears the decoder state, the queue and sets the color byte to 28.
module backslash_escape_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       string_end,
    output logic       run_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic [7:0]        color_reg;
    logic              consume;
    logic              accept;
    logic [1:0]        free;
    bed_pkg::dec_out_t dec;
    bed_pkg::result_t  head;

    // The held item moves on when the queue has room for all its results.
    assign consume   = in_valid_reg && (dec.count <= free);
    assign in_stall  = in_valid_reg && !consume;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_valid_next = accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Color escape register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= bed_pkg::COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            color_reg <= cfg_data;
        end
    end

    bed_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .consume    (consume),
        .byte_in    (in_byte_reg),
        .color_byte (color_reg),
        .dec        (dec)
    );

    bed_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (consume ? dec.count : 2'd0),
        .push0     (dec.res0),
        .push1     (dec.res1),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .free      (free)
    );

    assign out_byte   = head.out_byte;
    assign string_end = head.string_end;
    assign run_end    = head.run_end;

endmodule

### sv/bed_decode.sv
// Escape decoder state and the per-item decode logic.
module bed_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               consume,
    input  logic [7:0]         byte_in,
    input  logic [7:0]         color_byte,
    output bed_pkg::dec_out_t  dec
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_COLOUR = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCTAL  = 3'd4
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  count_reg, count_next;
    logic [8:0]  accum_reg, accum_next;

    // Decode one byte against the current state.
    always_comb
    begin
        bed_pkg::result_t res [2];
        logic [1:0] n;
        logic       do_plain;
        logic       is_hex;
        logic [3:0] hex_d;
        logic [8:0] acc_tmp;
        logic [1:0] cnt_tmp;

        mode_next  = mode_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;
        do_plain   = 1'b0;
        acc_tmp    = '0;
        cnt_tmp    = '0;

        // Hex digit value of the incoming byte.
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (byte_in inside {[bed_pkg::CHAR_0 : bed_pkg::CHAR_9]})
        begin
            hex_d = 4'(byte_in - bed_pkg::CHAR_0);
        end
        else if (byte_in inside {[bed_pkg::CHAR_A_LOWER : bed_pkg::CHAR_F_LOWER]})
        begin
            hex_d = 4'(byte_in - bed_pkg::CHAR_A_LOWER + 8'd10);
        end
        else if (byte_in inside {[bed_pkg::CHAR_A_UPPER : bed_pkg::CHAR_F_UPPER]})
        begin
            hex_d = 4'(byte_in - bed_pkg::CHAR_A_UPPER + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end

        case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_next = MODE_NORMAL;
                if (byte_in == bed_pkg::CHAR_NUL)
                begin
                    res[n[0]] = '{out_byte: 8'd0, string_end: 1'b1, run_end: 1'b0};
                    n = n + 2'd1;
                    count_next = '0;
                    accum_next = '0;
                end
                else if (byte_in == bed_pkg::CHAR_C)
                begin
                    mode_next = MODE_COLOUR;
                end
                else if (byte_in == bed_pkg::CHAR_N)
                begin
                    res[n[0]] = '{out_byte: bed_pkg::BYTE_LF, string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                end
                else if (byte_in == bed_pkg::CHAR_T)
                begin
                    res[n[0]] = '{out_byte: bed_pkg::BYTE_HT, string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                end
                else if (byte_in == bed_pkg::CHAR_R)
                begin
                    res[n[0]] = '{out_byte: bed_pkg::BYTE_CR, string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                end
                else if (byte_in == bed_pkg::CHAR_X_LOWER || byte_in == bed_pkg::CHAR_X_UPPER)
                begin
                    mode_next  = MODE_HEX;
                    count_next = '0;
                    accum_next = '0;
                end
                else if (byte_in inside {[bed_pkg::CHAR_0 : bed_pkg::CHAR_7]})
                begin
                    mode_next  = MODE_OCTAL;
                    count_next = 2'd1;
                    accum_next = {6'd0, byte_in[2:0]};
                end
                else
                begin
                    res[n[0]] = '{out_byte: byte_in, string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                end
            end

            MODE_COLOUR:
            begin
                // A color escape right before the terminator is dropped.
                mode_next = MODE_NORMAL;
                if (byte_in != bed_pkg::CHAR_NUL)
                begin
                    res[n[0]] = '{out_byte: color_byte, string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                end
                do_plain = 1'b1;
            end

            MODE_HEX:
            begin
                if (is_hex)
                begin
                    acc_tmp    = {accum_reg[4:0], hex_d};
                    cnt_tmp    = count_reg + 2'd1;
                    accum_next = acc_tmp;
                    count_next = cnt_tmp;
                    if (cnt_tmp >= 2'd2)
                    begin
                        res[n[0]] = '{out_byte: acc_tmp[7:0], string_end: 1'b0, run_end: 1'b0};
                        n = n + 2'd1;
                        mode_next  = MODE_NORMAL;
                        count_next = '0;
                        accum_next = '0;
                    end
                end
                else
                begin
                    res[n[0]] = '{out_byte: accum_reg[7:0], string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                    mode_next  = MODE_NORMAL;
                    count_next = '0;
                    accum_next = '0;
                    do_plain   = 1'b1;
                end
            end

            MODE_OCTAL:
            begin
                // The value shifts only when a valid octal digit arrives.
                if (byte_in inside {[bed_pkg::CHAR_0 : bed_pkg::CHAR_7]})
                begin
                    acc_tmp    = {accum_reg[5:0], byte_in[2:0]};
                    cnt_tmp    = count_reg + 2'd1;
                    accum_next = acc_tmp;
                    count_next = cnt_tmp;
                    if (cnt_tmp >= 2'd3)
                    begin
                        res[n[0]] = '{out_byte: acc_tmp[7:0], string_end: 1'b0, run_end: 1'b0};
                        n = n + 2'd1;
                        mode_next  = MODE_NORMAL;
                        count_next = '0;
                        accum_next = '0;
                    end
                end
                else
                begin
                    res[n[0]] = '{out_byte: accum_reg[7:0], string_end: 1'b0, run_end: 1'b0};
                    n = n + 2'd1;
                    mode_next  = MODE_NORMAL;
                    count_next = '0;
                    accum_next = '0;
                    do_plain   = 1'b1;
                end
            end

            default:
            begin
                mode_next = MODE_NORMAL;
                do_plain  = 1'b1;
            end
        endcase

        // Normal-mode handling of the byte, where the escape hands it back.
        if (do_plain)
        begin
            if (byte_in == bed_pkg::CHAR_NUL)
            begin
                res[n[0]] = '{out_byte: 8'd0, string_end: 1'b1, run_end: 1'b0};
                n = n + 2'd1;
                mode_next  = MODE_NORMAL;
                count_next = '0;
                accum_next = '0;
            end
            else if (byte_in == bed_pkg::CHAR_BACKSLASH)
            begin
                mode_next = MODE_ESCAPE;
            end
            else
            begin
                res[n[0]] = '{out_byte: byte_in, string_end: 1'b0, run_end: 1'b0};
                n = n + 2'd1;
            end
        end

        // Mark the last result of this item.
        if (n == 2'd1)
        begin
            res[0].run_end = 1'b1;
        end
        else if (n == 2'd2)
        begin
            res[1].run_end = 1'b1;
        end

        dec.count = n;
        dec.res0  = res[0];
        dec.res1  = res[1];
    end

    // Decoder state advances when the item is handed to the result queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
            accum_reg <= '0;
        end
        else if (consume)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
        end
    end

endmodule

### sv/bed_outq.sv
// Two-entry result queue that decouples the decoder from the output stall.
module bed_outq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_n,
    input  bed_pkg::result_t   push0,
    input  bed_pkg::result_t   push1,
    input  logic               out_stall,
    output logic               out_valid,
    output bed_pkg::result_t   head,
    output logic [1:0]         free
);

    bed_pkg::result_t q_reg [bed_pkg::QUEUE_DEPTH];
    bed_pkg::result_t q_next [bed_pkg::QUEUE_DEPTH];
    logic [1:0]       cnt_reg, cnt_next;
    logic             pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = q_reg[0];
    assign pop       = out_valid && !out_stall;

    // Room for new results, counting the entry that leaves in this cycle.
    assign free      = 2'(bed_pkg::QUEUE_DEPTH) - cnt_reg + {1'b0, pop};

    // Pop the head, then append the new results behind what remains.
    always_comb
    begin
        logic [1:0] tc;

        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        tc        = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            tc        = cnt_reg - 2'd1;
        end
        case (push_n)
            2'd1:
            begin
                q_next[tc[0]] = push0;
            end
            2'd2:
            begin
                q_next[0] = push0;
                q_next[1] = push1;
            end
            default:
            begin
            end
        endcase
        cnt_next = tc + push_n;
    end

    // Fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

### sv/bed_checker.sv
// Port-level checks for the backslash escape decoder and their bind.
module bed_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       string_end,
    input logic       run_end,
    input logic       cfg_ready
);

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(string_end) && $stable(run_end))
    else $error("stalled result item changed");

    // A terminator result is a zero byte and closes its input item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> out_byte == 8'd0 && run_end)
    else $error("terminator result malformed");

    // Input back-pressure only arises while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with empty result queue");

    // The configuration write is always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("configuration port not ready");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .string_end (string_end),
    .run_end    (run_end),
    .cfg_ready  (cfg_ready)
);
